// File: hw/rtl/lpg_pkg.sv
`timescale 1ns / 1ps

package lpg_pkg;

	localparam int GLYPH_BITS = 8;

	typedef logic [GLYPH_BITS-1:0] glyph_t;

endpackage

// File: hw/rtl/lpg_if.sv
`timescale 1ns / 1ps

interface lpg_req_if import lpg_pkg::*; #(
	parameter int CB = 6
) ();
	logic          valid;
	logic          ready;
	logic [CB-1:0] x_start;
	logic [CB-1:0] y_start;
	logic [CB-1:0] x_end;
	logic [CB-1:0] y_end;
	glyph_t        glyph_in;

	modport source (output valid, x_start, y_start, x_end, y_end, glyph_in, input ready);
	modport sink (input valid, x_start, y_start, x_end, y_end, glyph_in, output ready);
endinterface

interface lpg_pnt_if import lpg_pkg::*; #(
	parameter int CB = 6
) ();
	logic          valid;
	logic          ready;
	logic [CB-1:0] point_x;
	logic [CB-1:0] point_y;
	glyph_t        glyph_out;
	logic          last_point;

	modport source (output valid, point_x, point_y, glyph_out, last_point, input ready);
	modport sink (input valid, point_x, point_y, glyph_out, last_point, output ready);
endinterface

// File: hw/rtl/line_point_generator_core.sv
`timescale 1ns / 1ps
// An accepted request passes stage 1, stage 2 and the walker before its first point
// reaches the output register. The walker emits one point per cycle while the output is
// not stalled, and a line has between 1 and 2^COORD_BITS points.
// Two setup stages take the next request while a line is walked.
// Reset (arst_n low, asynchronous) empties all stages and the output register.
module line_point_generator_core import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	lpg_req_if.sink          req,
	lpg_pnt_if.source        pnt
);
	localparam int C = COORD_BITS;

	// stage 1: raw endpoints
	logic         v_s1;
	logic [C-1:0] xa_s1, ya_s1, xb_s1, yb_s1;
	glyph_t       g_s1;
	// stage 2: ordered endpoints
	logic         v_s2;
	logic [C-1:0] xa_s2, ya_s2, xb_s2, yb_s2;
	glyph_t       g_s2;
	// walker
	logic                busy_q;
	logic                xmaj_q;
	logic [C-1:0]        t_q, end_q, q_q, d_q;
	logic signed [C+1:0] r_q;
	logic signed [C:0]   delta_q;
	glyph_t              g_q;
	// output register
	logic         ov_q;
	logic [C-1:0] px_q, py_q;
	glyph_t       go_q;
	logic         last_q;

	logic         emit, is_last, load, adv2;
	logic [C-1:0] adx, ady;
	logic         flip;
	logic signed [C:0] dx, dy;
	logic         xmaj_n;
	logic [C-1:0] s_n, e_n, a_n, b_n, d_n;
	logic signed [C+1:0] r_sum, r_next;
	logic [C-1:0] q_next;

	assign is_last = (t_q == end_q);
	assign emit    = busy_q && (!ov_q || pnt.ready);
	assign load    = v_s2 && (!busy_q || (emit && is_last));
	assign adv2    = !v_s2 || load;
	assign req.ready = !v_s1 || adv2;

	always_comb begin
		adx  = (xa_s1 > xb_s1) ? xa_s1 - xb_s1 : xb_s1 - xa_s1;
		ady  = (ya_s1 > yb_s1) ? ya_s1 - yb_s1 : yb_s1 - ya_s1;
		flip = (adx > ady) ? (xa_s1 > xb_s1) : (ya_s1 > yb_s1);
	end

	always_comb begin
		dx     = $signed({1'b0, xb_s2}) - $signed({1'b0, xa_s2});
		dy     = $signed({1'b0, yb_s2}) - $signed({1'b0, ya_s2});
		xmaj_n = (dx >= dy);
		s_n    = xmaj_n ? xa_s2 : ya_s2;
		e_n    = xmaj_n ? xb_s2 : yb_s2;
		a_n    = xmaj_n ? ya_s2 : xa_s2;
		b_n    = xmaj_n ? yb_s2 : xb_s2;
		d_n    = e_n - s_n;
	end

	// step the remainder by the minor slope; one correction keeps it in [0, d)
	always_comb begin
		r_sum = r_q + {delta_q[C], delta_q};
		if (r_sum >= $signed({2'b00, d_q})) begin
			r_next = r_sum - $signed({2'b00, d_q});
			q_next = q_q + 1'b1;
		end else if (r_sum < 0) begin
			r_next = r_sum + $signed({2'b00, d_q});
			q_next = q_q - 1'b1;
		end else begin
			r_next = r_sum;
			q_next = q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (req.ready)
				v_s1 <= req.valid;
			if (adv2)
				v_s2 <= v_s1;
			if (load)
				busy_q <= 1'b1;
			else if (emit && is_last)
				busy_q <= 1'b0;
			if (emit)
				ov_q <= 1'b1;
			else if (pnt.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			xa_s1 <= req.x_start;
			ya_s1 <= req.y_start;
			xb_s1 <= req.x_end;
			yb_s1 <= req.y_end;
			g_s1  <= req.glyph_in;
		end
		if (adv2) begin
			xa_s2 <= flip ? xb_s1 : xa_s1;
			ya_s2 <= flip ? yb_s1 : ya_s1;
			xb_s2 <= flip ? xa_s1 : xb_s1;
			yb_s2 <= flip ? ya_s1 : yb_s1;
			g_s2  <= g_s1;
		end
		if (load) begin
			xmaj_q  <= xmaj_n;
			t_q     <= s_n;
			end_q   <= e_n;
			q_q     <= a_n;
			d_q     <= d_n;
			// start the remainder at half the major span for rounding
			r_q     <= $signed({3'b000, d_n[C-1:1]});
			delta_q <= $signed({1'b0, b_n}) - $signed({1'b0, a_n});
			g_q     <= g_s2;
		end else if (emit) begin
			t_q <= t_q + 1'b1;
			q_q <= q_next;
			r_q <= r_next;
		end
		if (emit) begin
			px_q   <= xmaj_q ? t_q : q_q;
			py_q   <= xmaj_q ? q_q : t_q;
			go_q   <= g_q;
			last_q <= is_last;
		end
	end

	assign pnt.valid      = ov_q;
	assign pnt.point_x    = px_q;
	assign pnt.point_y    = py_q;
	assign pnt.glyph_out  = go_q;
	assign pnt.last_point = last_q;

endmodule

// File: test/tb_line_point_generator_core.sv
`timescale 1ns / 1ps

module tb_line_point_generator_core;
	import lpg_pkg::*;

	localparam int CB = 6;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [CB-1:0] xs;
		logic [CB-1:0] ys;
		logic [CB-1:0] xe;
		logic [CB-1:0] ye;
		glyph_t        glyph;
	} line_req_t;

	typedef struct packed {
		logic [CB-1:0] px;
		logic [CB-1:0] py;
		glyph_t        glyph;
		logic          last;
	} point_t;

	logic clk;
	logic arst_n;

	lpg_req_if #(.CB(CB)) req ();
	lpg_pnt_if #(.CB(CB)) pnt ();

	line_point_generator_core #(.COORD_BITS(CB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.pnt(pnt.source)
	);

	line_req_t pending_lines[$];
	point_t    expected_points[$];
	int        errors = 0;
	int        cycles = 0;
	int        send_idle = 10;
	int        recv_idle = 68;
	int        hold_off = 400;
	bit        req_taken = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input point_t got, input point_t exp);
		$display("mismatch %s: got x=%0d y=%0d g=%0d l=%0d exp x=%0d y=%0d g=%0d l=%0d",
			what, got.px, got.py, got.glyph, got.last, exp.px, exp.py, exp.glyph, exp.last);
		errors++;
	endtask

	// Rasterize one request into its points, in output order.
	task automatic rasterize(input line_req_t r);
		int xa, ya, xb, yb, adx, ady, d, t, tmp;
		point_t p;
		xa = r.xs; ya = r.ys; xb = r.xe; yb = r.ye;
		adx = (xa > xb) ? xa - xb : xb - xa;
		ady = (ya > yb) ? ya - yb : yb - ya;
		if ((adx > ady) ? (xa > xb) : (ya > yb)) begin
			tmp = xa; xa = xb; xb = tmp;
			tmp = ya; ya = yb; yb = tmp;
		end
		p.glyph = r.glyph;
		if (xb - xa >= yb - ya) begin
			d = xb - xa;
			if (d == 0) begin
				p.px = CB'(xa); p.py = CB'(ya); p.last = 1'b1;
				expected_points.push_back(p);
			end else begin
				for (t = xa; t <= xb; t++) begin
					p.px = CB'(t);
					p.py = CB'((ya * (xb - t) + yb * (t - xa) + d / 2) / d);
					p.last = (t == xb);
					expected_points.push_back(p);
				end
			end
		end else begin
			d = yb - ya;
			for (t = ya; t <= yb; t++) begin
				p.py = CB'(t);
				p.px = CB'((xa * (yb - t) + xb * (t - ya) + d / 2) / d);
				p.last = (t == yb);
				expected_points.push_back(p);
			end
		end
	endtask

	function automatic line_req_t make_line(input int xs, ys, xe, ye, g);
		line_req_t r;
		r.xs = CB'(xs); r.ys = CB'(ys); r.xe = CB'(xe); r.ye = CB'(ye);
		r.glyph = GLYPH_BITS'(g);
		return r;
	endfunction

	initial begin
		int i, len, x0, y0;
		pending_lines.push_back(make_line(0, 0, 0, 0, 0));
		pending_lines.push_back(make_line(63, 63, 63, 63, 255));
		pending_lines.push_back(make_line(0, 0, 63, 0, 8'h41));
		pending_lines.push_back(make_line(63, 0, 0, 0, 8'h42));
		pending_lines.push_back(make_line(0, 0, 0, 63, 8'h43));
		pending_lines.push_back(make_line(0, 63, 0, 0, 8'h44));
		pending_lines.push_back(make_line(0, 0, 63, 63, 8'h55));
		pending_lines.push_back(make_line(63, 63, 0, 0, 8'hAA));
		pending_lines.push_back(make_line(0, 63, 63, 0, 8'h0F));
		pending_lines.push_back(make_line(63, 0, 0, 63, 8'hF0));
		pending_lines.push_back(make_line(5, 10, 10, 5, 1));
		pending_lines.push_back(make_line(3, 4, 60, 20, 2));
		pending_lines.push_back(make_line(60, 20, 3, 4, 3));
		pending_lines.push_back(make_line(10, 2, 20, 61, 4));
		pending_lines.push_back(make_line(20, 61, 10, 2, 5));
		pending_lines.push_back(make_line(7, 7, 8, 9, 6));
		pending_lines.push_back(make_line(8, 9, 7, 7, 7));
		pending_lines.push_back(make_line(1, 1, 2, 2, 8));
		pending_lines.push_back(make_line(42, 21, 43, 21, 9));
		pending_lines.push_back(make_line(63, 1, 62, 0, 10));
		for (i = 0; i < 450; i++) begin
			if (i % 10 == 0) begin
				// full-range endpoints, mostly long lines
				pending_lines.push_back(make_line($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255)));
			end else begin
				len = $urandom_range(0, 7);
				x0 = $urandom_range(0, 63);
				y0 = $urandom_range(0, 63);
				pending_lines.push_back(make_line(x0, y0,
					(x0 + $urandom_range(0, 2 * len) - len) & 63,
					(y0 + $urandom_range(0, 2 * len) - len) & 63, $urandom_range(0, 255)));
			end
		end
	end

	// Driver: advance only after the request was taken at the last rising edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_taken) begin
			if (pending_lines.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				{req.x_start, req.y_start, req.x_end, req.y_end, req.glyph_in} <=
					pending_lines.pop_front();
				req.valid <= 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Scoreboard feed: predict on each accepted request
	always @(posedge clk) begin
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready)
			rasterize({req.x_start, req.y_start, req.x_end, req.y_end, req.glyph_in});
	end

	// Receiver ready; hold off for a long stretch right after reset
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnt.ready <= 1'b0;
		end else if (hold_off > 0) begin
			pnt.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			pnt.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Monitor
	always @(posedge clk) begin
		point_t got, exp;
		if (arst_n && pnt.valid && pnt.ready) begin
			got = {pnt.point_x, pnt.point_y, pnt.glyph_out, pnt.last_point};
			if (expected_points.size() == 0) begin
				report("unexpected point", got, got);
			end else begin
				exp = expected_points.pop_front();
				if (got.px !== exp.px) report("point_x", got, exp);
				if (got.py !== exp.py) report("point_y", got, exp);
				if (got.glyph !== exp.glyph) report("glyph_out", got, exp);
				if (got.last !== exp.last) report("last_point", got, exp);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[line_point_generator_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_lines.size() <= 310);
		send_idle = 68;
		recv_idle = 10;
		wait (pending_lines.size() <= 160);
		send_idle = 0;
		recv_idle = 0;
		wait (pending_lines.size() == 0);
		@(posedge clk);
		while (req.valid) @(posedge clk);
		wait (expected_points.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("[line_point_generator_core] OK");
		end else begin
			$display("[line_point_generator_core] ERROR");
		end
		$finish;
	end

endmodule
